// ----- rtl/mip_2d_layout_address_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Mip 2D layout address unit: assertion macros
// Shared macros for the concurrent checks on the address unit's ports.
// ----------------------------------------------------------------------------
`ifndef MIP_2D_LAYOUT_ADDRESS_UNIT_DEFINES_SVH
`define MIP_2D_LAYOUT_ADDRESS_UNIT_DEFINES_SVH

// Check that is switched off while reset is held.
`define MIP2D_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Check that also watches the reset cycles themselves.
`define MIP2D_ASSERT_RESET(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- rtl/mip2d_pkg.sv -----
// ----------------------------------------------------------------------------
// Mip 2D layout package
// Widths, codes, stage types and the extent helpers used by the address unit.
// ----------------------------------------------------------------------------
package mip2d_pkg;

    // Default depth of the level chain, one cell per mip level.
    localparam int DEF_LEVEL_CELLS = 15;

    // Fixed geometry of the layout.
    localparam int MAX_EXTENT        = 16384;
    localparam int LEVEL_ALIGN       = 4;
    localparam int TEXEL_SHIFT       = 2;
    localparam int DEPTH_PITCH_ALIGN = 128;
    localparam int DEPTH_ROW_ALIGN   = 32;

    // Field widths.
    localparam int FMT_W   = 2;
    localparam int EXT_W   = 15;
    localparam int LVL_W   = 4;
    localparam int STAT_W  = 3;
    localparam int HGT_W   = 16;
    localparam int PITCH_W = 17;
    localparam int ROWS_W  = 16;
    localparam int BYTE_W  = 32;
    localparam int MUL_W   = PITCH_W + ROWS_W;

    // Reciprocal used to round an extent up to the level alignment.
    localparam int ALIGN_SHIFT = 22;
    localparam int ALIGN_RECIP = (2 ** ALIGN_SHIFT + LEVEL_ALIGN - 1) / LEVEL_ALIGN;
    localparam int ALIGN_PROD_W = EXT_W + 1 + ALIGN_SHIFT + 1;
    localparam int ALIGN_SCALE_W = EXT_W + 8;

    // Format classes.
    localparam logic [FMT_W-1:0] FMT_DEPTH = 2'd2;
    localparam logic [FMT_W-1:0] FMT_BAD   = 2'd3;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 3'd0,
        ST_BAD_FORMAT = 3'd1,
        ST_EMPTY      = 3'd2,
        ST_BAD_LEVELS = 3'd3,
        ST_MIP_DEPTH  = 3'd4,
        ST_ABSENT     = 3'd5
    } status_t;

    // Data handed from one level cell to the next.
    typedef struct packed {
        status_t            status;
        logic               depth;
        logic [EXT_W-1:0]   img_w;
        logic [EXT_W-1:0]   img_h;
        logic [LVL_W-1:0]   levels;
        logic [LVL_W-1:0]   query;
        logic [EXT_W-1:0]   top_w;
        logic [EXT_W-1:0]   bot_w;
        logic [HGT_W-1:0]   left_h;
        logic [HGT_W-1:0]   right_h;
        logic [EXT_W-1:0]   org_x;
        logic [HGT_W-1:0]   org_y;
        logic [EXT_W-1:0]   lvl_w;
        logic [EXT_W-1:0]   lvl_h;
    } chain_t;

    // Pitch and row count stage.
    typedef struct packed {
        status_t            status;
        logic               single;
        logic [PITCH_W-1:0] pitch;
        logic [ROWS_W-1:0]  rows;
        logic [EXT_W-1:0]   org_x;
        logic [HGT_W-1:0]   org_y;
        logic [EXT_W-1:0]   lvl_w;
        logic [EXT_W-1:0]   lvl_h;
        logic [EXT_W-1:0]   lvl_h_m1;
    } stage1_t;

    // Product stage, handed to the output register.
    typedef struct packed {
        status_t            status;
        logic               single;
        logic [PITCH_W-1:0] pitch;
        logic [BYTE_W-1:0]  bytes;
        logic [BYTE_W-1:0]  off_mul;
        logic [BYTE_W-1:0]  size_mul;
        logic [EXT_W-1:0]   org_x;
        logic [HGT_W-1:0]   org_y;
        logic [EXT_W-1:0]   lvl_w;
        logic [EXT_W-1:0]   lvl_h;
    } post_t;

    // Rounds an extent up to LEVEL_ALIGN through a reciprocal multiply,
    // exact for every biased extent below 2**15.
    function automatic logic [EXT_W-1:0] align_up(input logic [EXT_W-1:0] x);
        logic [EXT_W:0]         biased;
        logic [ALIGN_PROD_W-1:0] prod;
        logic [EXT_W:0]         quot;
        logic [ALIGN_SCALE_W-1:0] scaled;
        biased = {1'b0, x} + (EXT_W + 1)'(LEVEL_ALIGN - 1);
        prod   = ALIGN_PROD_W'(biased) * ALIGN_PROD_W'(ALIGN_RECIP);
        quot   = prod[ALIGN_SHIFT +: EXT_W + 1];
        scaled = ALIGN_SCALE_W'(quot) * ALIGN_SCALE_W'(LEVEL_ALIGN);
        return scaled[EXT_W-1:0];
    endfunction

    // Number of significant bits of a non-zero extent.
    function automatic logic [LVL_W-1:0] bit_length(input logic [EXT_W-1:0] x);
        logic [LVL_W-1:0] n;
        n = '0;
        for (int i = 0; i < EXT_W; i++) begin
            if (x[i]) begin
                n = LVL_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

// ----- rtl/mip_2d_layout_address_unit.sv -----
// ----------------------------------------------------------------------------
// Mip 2D layout address unit
// Places one mip level of a 2D image in the shared-pitch mip arrangement.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one image description and a queried level per
//   beat; the m_ channel returns status, row pitch, total bytes and the
//   queried level's origin, byte offset, size and extent, one beat per input.
//   A beat walks a row of LEVEL_CELLS level cells, one cell per cycle, then
//   a pitch stage and a multiply stage, and m_valid rises once the result
//   is loaded into the output register.
//   Only one beat is in the cells at a time: s_ready returns as the result
//   enters the output register, so a new beat waits until the last one has
//   left the cells and stages; the length of the cell row sets that wait.
//   A finished result waits in the output register, and the next beat is
//   taken meanwhile. If the receiver stalls for longer, that beat holds in
//   the last stage and s_ready stays low until the result is taken.
//   Reset (aresetn low, synchronous) empties the pipeline and the output.
// ----------------------------------------------------------------------------
module mip_2d_layout_address_unit
    import mip2d_pkg::*;
#(
    parameter int LEVEL_CELLS = DEF_LEVEL_CELLS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [FMT_W-1:0]    s_format_class,
    input  logic [EXT_W-1:0]    s_image_width,
    input  logic [EXT_W-1:0]    s_image_height,
    input  logic [LVL_W-1:0]    s_level_total,
    input  logic [LVL_W-1:0]    s_query_level,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STAT_W-1:0]   m_status,
    output logic [PITCH_W-1:0]  m_row_pitch,
    output logic [BYTE_W-1:0]   m_total_bytes,
    output logic [EXT_W-1:0]    m_origin_x,
    output logic [HGT_W-1:0]    m_origin_y,
    output logic [BYTE_W-1:0]   m_level_offset,
    output logic [BYTE_W-1:0]   m_level_size,
    output logic [EXT_W-1:0]    m_lvl_width,
    output logic [EXT_W-1:0]    m_lvl_height
);

    localparam int NUM_STAGES = LEVEL_CELLS + 2;

    logic [NUM_STAGES-1:0] stage_vld_reg;
    logic [NUM_STAGES-1:0] stage_vld_next;
    logic                  out_vld_reg;
    logic                  out_vld_next;
    logic                  advance;
    logic                  accept;
    logic                  load_out;
    logic [EXT_W-1:0]      big_side;
    logic [LVL_W-1:0]      level_cap;
    chain_t                head;
    chain_t                tail;
    post_t                 post;

    logic [STAT_W-1:0]     status_reg;
    logic [PITCH_W-1:0]    pitch_reg;
    logic [BYTE_W-1:0]     bytes_reg;
    logic [EXT_W-1:0]      org_x_reg;
    logic [HGT_W-1:0]      org_y_reg;
    logic [BYTE_W-1:0]     offset_reg;
    logic [BYTE_W-1:0]     offset_next;
    logic [BYTE_W-1:0]     size_reg;
    logic [BYTE_W-1:0]     size_next;
    logic [EXT_W-1:0]      lvl_w_reg;
    logic [EXT_W-1:0]      lvl_h_reg;

    // Handshake: the pipeline moves unless the last stage is blocked.
    // No beat is taken while reset is held.
    assign advance  = !(stage_vld_reg[NUM_STAGES-1] && out_vld_reg && !m_ready);
    assign s_ready  = aresetn && (stage_vld_reg == '0);
    assign accept   = s_valid && s_ready;
    assign load_out = stage_vld_reg[NUM_STAGES-1] && advance;

    // Level limit from the larger side, capped at the chain length.
    always_comb begin
        big_side  = (s_image_height > s_image_width) ? s_image_height : s_image_width;
        level_cap = bit_length(big_side);
        if (level_cap > LVL_W'(LEVEL_CELLS)) begin
            level_cap = LVL_W'(LEVEL_CELLS);
        end
    end

    // Error checks in priority order, and the empty sums for the first cell.
    always_comb begin
        head        = '0;
        head.depth  = (s_format_class == FMT_DEPTH);
        head.img_w  = s_image_width;
        head.img_h  = s_image_height;
        head.levels = s_level_total;
        head.query  = s_query_level;
        if (s_format_class == FMT_BAD) begin
            head.status = ST_BAD_FORMAT;
        end else if (s_image_width == '0 || s_image_height == '0
                     || s_image_width > EXT_W'(MAX_EXTENT)
                     || s_image_height > EXT_W'(MAX_EXTENT)) begin
            head.status = ST_EMPTY;
        end else if (s_level_total == '0 || s_level_total > level_cap) begin
            head.status = ST_BAD_LEVELS;
        end else if (s_level_total != LVL_W'(1) && s_format_class == FMT_DEPTH) begin
            head.status = ST_MIP_DEPTH;
        end else if (s_query_level >= s_level_total) begin
            head.status = ST_ABSENT;
        end else begin
            head.status = ST_OK;
        end
    end

    mip2d_chain #(
        .NUM_CELLS (LEVEL_CELLS)
    ) u_chain (
        .aclk      (aclk),
        .en        (advance),
        .chain_in  (head),
        .chain_out (tail)
    );

    mip2d_size_unit u_size (
        .aclk (aclk),
        .en   (advance),
        .sums (tail),
        .post (post)
    );

    // Stage valid bits and output valid.
    always_comb begin
        stage_vld_next = stage_vld_reg;
        if (advance) begin
            stage_vld_next = {stage_vld_reg[NUM_STAGES-2:0], accept};
        end
        out_vld_next = out_vld_reg;
        if (load_out) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_vld_reg <= '0;
            out_vld_reg   <= 1'b0;
        end else begin
            stage_vld_reg <= stage_vld_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    // Final adds for offset and size.
    always_comb begin
        offset_next = post.off_mul + (BYTE_W'(post.org_x) << TEXEL_SHIFT);
        if (post.single) begin
            size_next = post.bytes;
        end else begin
            size_next = post.size_mul + (BYTE_W'(post.lvl_w) << TEXEL_SHIFT);
        end
    end

    // Output register for the result beat.
    always_ff @(posedge aclk) begin
        if (load_out) begin
            status_reg <= post.status;
            pitch_reg  <= post.pitch;
            bytes_reg  <= post.bytes;
            org_x_reg  <= post.org_x;
            org_y_reg  <= post.org_y;
            offset_reg <= offset_next;
            size_reg   <= size_next;
            lvl_w_reg  <= post.lvl_w;
            lvl_h_reg  <= post.lvl_h;
        end
    end

    assign m_valid        = out_vld_reg;
    assign m_status       = status_reg;
    assign m_row_pitch    = pitch_reg;
    assign m_total_bytes  = bytes_reg;
    assign m_origin_x     = org_x_reg;
    assign m_origin_y     = org_y_reg;
    assign m_level_offset = offset_reg;
    assign m_level_size   = size_reg;
    assign m_lvl_width    = lvl_w_reg;
    assign m_lvl_height   = lvl_h_reg;

endmodule

// ----- rtl/mip2d_level_cell.sv -----
// ----------------------------------------------------------------------------
// Mip 2D level cell
// One mip level of the layout: adds its aligned extent to the running sums.
// ----------------------------------------------------------------------------
module mip2d_level_cell
    import mip2d_pkg::*;
#(
    parameter int LEVEL = 0
) (
    input  logic   aclk,
    input  logic   en,
    input  chain_t cell_in,
    output chain_t cell_out
);

    localparam logic [LVL_W-1:0] LEVEL_IDX = LVL_W'(LEVEL);

    chain_t           cell_reg;
    chain_t           cell_next;
    logic [EXT_W-1:0] raw_w;
    logic [EXT_W-1:0] raw_h;
    logic [EXT_W-1:0] aln_w;
    logic [EXT_W-1:0] aln_h;

    // Extent of this level, halved per level and never below one texel.
    always_comb begin
        raw_w = cell_in.img_w >> LEVEL;
        raw_h = cell_in.img_h >> LEVEL;
        if (raw_w == '0) begin
            raw_w = EXT_W'(1);
        end
        if (raw_h == '0) begin
            raw_h = EXT_W'(1);
        end
        aln_w = align_up(raw_w);
        aln_h = align_up(raw_h);
    end

    // Place the level: top row, bottom-left, then the right-hand column.
    always_comb begin
        cell_next = cell_in;
        if (LEVEL_IDX < cell_in.levels) begin
            if (LEVEL == 0) begin
                cell_next.top_w   = aln_w;
                cell_next.left_h  = HGT_W'(aln_h);
                cell_next.right_h = HGT_W'(aln_h);
            end else if (LEVEL == 1) begin
                cell_next.bot_w  = aln_w;
                cell_next.left_h = HGT_W'(cell_in.left_h + HGT_W'(aln_h));
            end else if (LEVEL == 2) begin
                cell_next.bot_w   = EXT_W'(cell_in.bot_w + aln_w);
                cell_next.right_h = HGT_W'(cell_in.right_h + HGT_W'(aln_h));
            end else begin
                cell_next.right_h = HGT_W'(cell_in.right_h + HGT_W'(aln_h));
            end
        end
        // Levels before the queried one push its origin right or down.
        if (LEVEL_IDX < cell_in.query) begin
            if (LEVEL == 1) begin
                cell_next.org_x = EXT_W'(cell_in.org_x + aln_w);
            end else begin
                cell_next.org_y = HGT_W'(cell_in.org_y + HGT_W'(aln_h));
            end
        end
        if (LEVEL_IDX == cell_in.query) begin
            cell_next.lvl_w = raw_w;
            cell_next.lvl_h = raw_h;
        end
    end

    // Hand the beat on to the next cell.
    always_ff @(posedge aclk) begin
        if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

// ----- rtl/mip2d_chain.sv -----
// ----------------------------------------------------------------------------
// Mip 2D level chain
// A row of level cells; a beat walks one cell per cycle while en is high.
// ----------------------------------------------------------------------------
module mip2d_chain
    import mip2d_pkg::*;
#(
    parameter int NUM_CELLS = DEF_LEVEL_CELLS
) (
    input  logic   aclk,
    input  logic   en,
    input  chain_t chain_in,
    output chain_t chain_out
);

    chain_t links [0:NUM_CELLS];

    assign links[0] = chain_in;

    // One cell for every level the image may have.
    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        mip2d_level_cell #(
            .LEVEL (g)
        ) u_cell (
            .aclk     (aclk),
            .en       (en),
            .cell_in  (links[g]),
            .cell_out (links[g+1])
        );
    end

    assign chain_out = links[NUM_CELLS];

endmodule

// ----- rtl/mip2d_size_unit.sv -----
// ----------------------------------------------------------------------------
// Mip 2D size unit
// Turns the summed layout into pitch and rows, then forms the byte products.
// ----------------------------------------------------------------------------
module mip2d_size_unit
    import mip2d_pkg::*;
(
    input  logic   aclk,
    input  logic   en,
    input  chain_t sums,
    output post_t  post
);

    stage1_t            st1_reg;
    stage1_t            st1_next;
    post_t              st2_reg;
    post_t              st2_next;
    logic [PITCH_W-1:0] lin_pitch;
    logic [EXT_W-1:0]   lay_w;
    logic [HGT_W-1:0]   lay_h;
    logic [MUL_W-1:0]   bytes_full;
    logic [MUL_W-1:0]   off_full;
    logic [MUL_W-1:0]   size_full;

    // Pitch and row count; an error beat is cleared to zero here.
    always_comb begin
        lin_pitch = PITCH_W'(sums.img_w) << TEXEL_SHIFT;
        lay_w     = (sums.bot_w > sums.top_w) ? sums.bot_w : sums.top_w;
        lay_h     = (sums.right_h > sums.left_h) ? sums.right_h : sums.left_h;
        st1_next  = '0;
        st1_next.status = sums.status;
        if (sums.status == ST_OK) begin
            st1_next.single   = (sums.levels == LVL_W'(1));
            st1_next.org_x    = sums.org_x;
            st1_next.org_y    = sums.org_y;
            st1_next.lvl_w    = sums.lvl_w;
            st1_next.lvl_h    = sums.lvl_h;
            st1_next.lvl_h_m1 = EXT_W'(sums.lvl_h - EXT_W'(1));
            if (sums.levels == LVL_W'(1)) begin
                if (sums.depth) begin
                    st1_next.pitch = PITCH_W'(
                        ((PITCH_W + 1)'(lin_pitch) + (PITCH_W + 1)'(DEPTH_PITCH_ALIGN - 1))
                        & ~(PITCH_W + 1)'(DEPTH_PITCH_ALIGN - 1));
                    st1_next.rows = ROWS_W'(
                        ((ROWS_W + 1)'(sums.img_h) + (ROWS_W + 1)'(DEPTH_ROW_ALIGN - 1))
                        & ~(ROWS_W + 1)'(DEPTH_ROW_ALIGN - 1));
                end else begin
                    st1_next.pitch = lin_pitch;
                    st1_next.rows  = ROWS_W'(sums.img_h);
                end
            end else begin
                st1_next.pitch = PITCH_W'(lay_w) << TEXEL_SHIFT;
                st1_next.rows  = lay_h;
            end
        end
    end

    // The three byte products, one multiplier each.
    always_comb begin
        bytes_full = MUL_W'(st1_reg.pitch) * MUL_W'(st1_reg.rows);
        off_full   = MUL_W'(st1_reg.org_y) * MUL_W'(st1_reg.pitch);
        size_full  = MUL_W'(st1_reg.lvl_h_m1) * MUL_W'(st1_reg.pitch);
        st2_next.status   = st1_reg.status;
        st2_next.single   = st1_reg.single;
        st2_next.pitch    = st1_reg.pitch;
        st2_next.bytes    = bytes_full[BYTE_W-1:0];
        st2_next.off_mul  = off_full[BYTE_W-1:0];
        st2_next.size_mul = size_full[BYTE_W-1:0];
        st2_next.org_x    = st1_reg.org_x;
        st2_next.org_y    = st1_reg.org_y;
        st2_next.lvl_w    = st1_reg.lvl_w;
        st2_next.lvl_h    = st1_reg.lvl_h;
    end

    // Stage registers, advanced together with the chain.
    always_ff @(posedge aclk) begin
        if (en) begin
            st1_reg <= st1_next;
            st2_reg <= st2_next;
        end
    end

    assign post = st2_reg;

endmodule

// ----- rtl/mip2d_checker.sv -----
// ----------------------------------------------------------------------------
// Mip 2D layout checker
// Port-level checks on the address unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "mip_2d_layout_address_unit_defines.svh"

module mip2d_checker
    import mip2d_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [STAT_W-1:0]   m_status,
    input logic [PITCH_W-1:0]  m_row_pitch,
    input logic [BYTE_W-1:0]   m_total_bytes,
    input logic [EXT_W-1:0]    m_origin_x,
    input logic [HGT_W-1:0]    m_origin_y,
    input logic [BYTE_W-1:0]   m_level_offset,
    input logic [BYTE_W-1:0]   m_level_size,
    input logic [EXT_W-1:0]    m_lvl_width,
    input logic [EXT_W-1:0]    m_lvl_height
);

    // Reset empties the output register.
    `MIP2D_ASSERT_RESET(a_reset_clears_out, !aresetn |=> !m_valid, "m_valid high after reset")

    // Only one beat is in flight, so a taken beat closes the input.
    `MIP2D_ASSERT(a_one_in_flight, (s_valid && s_ready) |=> !s_ready, "s_ready held after a beat")

    // A result never appears in the cycle straight after its input.
    `MIP2D_ASSERT(a_min_latency, (s_valid && s_ready && !m_valid) |=> !m_valid,
        "result too early")

    // A failed query carries an all-zero layout.
    `MIP2D_ASSERT(a_error_zero, (m_valid && m_status != ST_OK) |->
        (m_row_pitch == '0 && m_total_bytes == '0 && m_origin_x == '0
         && m_origin_y == '0 && m_level_offset == '0 && m_level_size == '0
         && m_lvl_width == '0 && m_lvl_height == '0), "error beat has payload")

    // A good query has a real level and pitch.
    `MIP2D_ASSERT(a_ok_extent, (m_valid && m_status == ST_OK) |->
        (m_lvl_width != '0 && m_lvl_height != '0 && m_row_pitch != '0),
        "ok beat with empty extent")

endmodule

bind mip_2d_layout_address_unit mip2d_checker u_mip2d_checker (.*);
